// File: design/sipq_pkg.sv
`default_nettype none

package sipq_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 16;
	localparam int ValueW = 32;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_REMOVE = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// Broadcast from the top level to every cell of the chain.
	typedef struct packed {
		logic                     ins_en;
		logic                     rem_en;
		logic signed [ValueW-1:0] new_value;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/sipq_cell.sv
`default_nettype none

module sipq_cell
	import sipq_pkg::*;
(
	input  wire logic                     clk,
	input  wire cell_ctrl_t               ctrl,
	input  wire logic                     occupied,
	input  wire logic                     left_ge,
	input  wire logic signed [ValueW-1:0] left_value,
	input  wire logic signed [ValueW-1:0] right_value,
	output logic                          ge,
	output logic signed [ValueW-1:0]      value_q,
	output logic signed [ValueW-1:0]      next_value
);

	// A cell keeps its entry when it is at least the new value; equal entries stay
	// ahead, so ties leave in arrival order.
	assign ge = occupied && (value_q >= ctrl.new_value);

	always_comb begin
		next_value = value_q;
		if (ctrl.ins_en) begin
			if (ge) begin
				next_value = value_q;
			end else if (left_ge) begin
				next_value = ctrl.new_value;
			end else begin
				next_value = left_value;
			end
		end else if (ctrl.rem_en) begin
			next_value = right_value;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= next_value;
	end

endmodule

`default_nettype wire

// File: design/sorted_insert_priority_queue.sv
// Max-priority queue held as a chain of QUEUE_DEPTH cells sorted in descending
// order. Every cell compares its entry with the incoming value in parallel and
// then keeps it, takes the new value, or shifts in its neighbor's entry, so one
// beat is taken per clock while the input is not stalled and its result is
// registered in the output register. Equal values leave in arrival order. A
// remove on an empty queue and an insert on a full queue change nothing and are
// reported in status. Input stalls only while a finished result waits on a
// stalled output. occupancy shows the low five bits of the entry count.
`default_nettype none

module sorted_insert_priority_queue
	import sipq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     mode,
	input  wire logic signed [ValueW-1:0] value,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [ValueW-1:0]      head_value,
	output logic                          is_empty,
	output logic [4:0]                    occupancy,
	output logic [1:0]                    status
);

	localparam int CountW = $clog2(QUEUE_DEPTH + 1);

	logic [CountW-1:0] count_q, count_next;
	logic              accept, full, empty;
	status_t           stat_next;
	cell_ctrl_t        ctrl;

	logic                     ge        [QUEUE_DEPTH];
	logic                     occupied  [QUEUE_DEPTH];
	logic signed [ValueW-1:0] cell_val  [QUEUE_DEPTH];
	logic signed [ValueW-1:0] cell_next [QUEUE_DEPTH];

	logic signed [ValueW-1:0] head_q;
	logic                     empty_q;
	logic [CountW-1:0]        occ_q;
	status_t                  status_q;
	logic                     out_valid_q;
	logic [CountW+4:0]        occ_ext;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CountW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);

	always_comb begin
		ctrl.ins_en    = accept && (mode == MODE_INSERT) && !full;
		ctrl.rem_en    = accept && (mode == MODE_REMOVE) && !empty;
		ctrl.new_value = value;
		count_next     = count_q;
		stat_next      = STATUS_DONE;
		if (mode == MODE_INSERT) begin
			if (full) begin
				stat_next = STATUS_FULL;
			end else begin
				count_next = count_q + CountW'(1);
			end
		end else begin
			if (empty) begin
				stat_next = STATUS_EMPTY;
			end else begin
				count_next = count_q - CountW'(1);
			end
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                     l_ge;
		logic signed [ValueW-1:0] l_val, r_val;

		assign occupied[i] = (count_q > CountW'(i));

		if (i == 0) begin : g_first
			assign l_ge  = 1'b1;
			assign l_val = value;
		end else begin : g_mid
			assign l_ge  = ge[i-1];
			assign l_val = cell_val[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign r_val = cell_val[i];
		end else begin : g_inner
			assign r_val = cell_val[i+1];
		end

		sipq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (occupied[i]),
			.left_ge     (l_ge),
			.left_value  (l_val),
			.right_value (r_val),
			.ge          (ge[i]),
			.value_q     (cell_val[i]),
			.next_value  (cell_next[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_q   <= (count_next == '0) ? '0 : cell_next[0];
			empty_q  <= (count_next == '0);
			occ_q    <= count_next;
			status_q <= stat_next;
		end
	end

	assign occ_ext    = {5'b0, occ_q};
	assign out_valid  = out_valid_q;
	assign head_value = head_q;
	assign is_empty   = empty_q;
	assign occupancy  = occ_ext[4:0];
	assign status     = status_q;

endmodule

`default_nettype wire

// File: design/sipq_check.sv
`default_nettype none

module sipq_check
	import sipq_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_stall,
	input wire logic                     out_valid,
	input wire logic                     out_stall,
	input wire logic signed [ValueW-1:0] head_value,
	input wire logic                     is_empty,
	input wire logic [1:0]               status
);

	// An accepted beat always leaves a result in the output register.
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted beat produced no result");

	// A waiting result must hold off the input side.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result is stalled");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> head_value == '0)
		else $error("empty queue reports nonzero head");

	a_empty_remove: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_EMPTY |-> is_empty)
		else $error("ignored remove reports entries");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(head_value) && $stable(status))
		else $error("stalled result changed");

endmodule

bind sorted_insert_priority_queue sipq_check u_sipq_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.head_value (head_value),
	.is_empty   (is_empty),
	.status     (status)
);

`default_nettype wire
